// ----- rtl/core/lgrf_pkg.sv -----
// Shared constants and types for the local gray range filter.
package lgrf_pkg;

  localparam int unsigned MaxWidth   = 1024;
  localparam int unsigned MaxWindow  = 15;
  localparam int unsigned StoreRows  = 16;
  localparam int unsigned ColW       = $clog2(MaxWidth);
  localparam int unsigned SlotW      = $clog2(StoreRows);
  localparam int unsigned AddrW      = ColW + SlotW;
  localparam int unsigned StoreDepth = MaxWidth * StoreRows;

  localparam logic [10:0] WidthReset  = 11'd640;
  localparam logic [12:0] HeightReset = 13'd480;
  localparam logic [3:0]  WinReset    = 4'd3;
  localparam logic [7:0]  PixMax      = 8'd255;

  localparam logic [1:0] RegImageWidth  = 2'd0;
  localparam logic [1:0] RegImageHeight = 2'd1;
  localparam logic [1:0] RegWinHeight   = 2'd2;
  localparam logic [1:0] RegWinWidth    = 2'd3;

  localparam logic OpPixel = 1'b0;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SCAN,
    ST_DRAIN,
    ST_EMIT
  } lgrf_state_e;

endpackage

// ----- rtl/core/lgrf_ram.sv -----
// Single-port-write, single-port-read line store with registered read data.
module lgrf_ram #(
  parameter int unsigned Depth = 16384,
  parameter int unsigned DataW = 8,
  parameter int unsigned AW    = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [DataW-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [DataW-1:0] rdata_o
);

  logic [DataW-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

// ----- rtl/core/local_gray_range_filter.sv -----
// Local gray range filter: window max minus min over a raster-order frame.
// A word that completes no window is checked and the block returns to idle;
// one that completes a window gives its result after a scan of the window, a drain and an emit,
// since the line store has one read port and each window sample is read in turn.
// The block takes one word at a time and accepts no new word until it is back in idle; the scan
// is longest for a 15x15 window, and the wait grows while a waiting result is held off by the receiver.
// Reset: position counters and flags clear, registers return to 640/480/3/3;
// the line store is not cleared and needs no clearing pass.
module local_gray_range_filter
  import lgrf_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // slave stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] pixel
  input  logic        s_axis_tuser,   // [0] op (1 = drain)
  // master stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] range_value
  output logic        m_axis_tlast,   // frame_last
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // configuration registers
  logic [10:0] img_w_q;
  logic [12:0] img_h_q;
  logic [3:0]  win_h_q, win_w_q;
  logic        cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite;

  always_comb begin
    unique case (paddr[3:2])
      RegImageWidth:  prdata = {21'd0, img_w_q};
      RegImageHeight: prdata = {19'd0, img_h_q};
      RegWinHeight:   prdata = {28'd0, win_h_q};
      RegWinWidth:    prdata = {28'd0, win_w_q};
      default:        prdata = '0;
    endcase
  end

  // effective, clamped settings
  logic [10:0] w_eff;
  logic [12:0] h_eff;
  logic [3:0]  wh_eff, ww_eff;
  logic [3:0]  up, down, left, right;

  always_comb begin
    w_eff  = (img_w_q == '0) ? 11'd1 : (img_w_q > 11'(MaxWidth)) ? 11'(MaxWidth) : img_w_q;
    h_eff  = (img_h_q == '0) ? 13'd1 : (img_h_q > 13'd4096) ? 13'd4096 : img_h_q;
    wh_eff = (win_h_q == '0) ? 4'd1 : win_h_q;
    ww_eff = (win_w_q == '0) ? 4'd1 : win_w_q;
    up     = wh_eff >> 1;
    down   = wh_eff - 4'd1 - up;
    left   = ww_eff >> 1;
    right  = ww_eff - 4'd1 - left;
  end

  // frame position state
  logic [ColW-1:0] in_col_q, out_col_q;
  logic [11:0]     in_row_q, out_row_q;
  logic            in_done_q;

  // scan state
  lgrf_state_e     state_q, state_d;
  logic [11:0]     y_q, y1_q;
  logic [ColW-1:0] x_q, x0_q, x1_q;
  logic [7:0]      max_q, min_q;
  logic            rd_vld_q;
  logic            out_vld_q;
  logic [7:0]      out_data_q;
  logic            out_last_q;

  logic in_acc, out_free, ready_win, scan_end, is_last;
  logic [12:0] ry;
  logic [10:0] rx;
  logic [11:0] y0;
  logic [ColW-1:0] x0;
  logic [7:0] rd_data;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid & s_axis_tready;
  assign out_free      = ~out_vld_q | m_axis_tready;
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;

  // window bounds for the next pending result
  always_comb begin
    ry = {1'b0, out_row_q} + 13'(down);
    if (ry > h_eff - 13'd1) ry = h_eff - 13'd1;
    rx = {1'b0, out_col_q} + 11'(right);
    if (rx > w_eff - 11'd1) rx = w_eff - 11'd1;
    y0 = (out_row_q >= 12'(up)) ? out_row_q - 12'(up) : '0;
    x0 = (out_col_q >= ColW'(left)) ? out_col_q - ColW'(left) : '0;
    ready_win = in_done_q || ({1'b0, in_row_q} > ry) ||
                (({1'b0, in_row_q} == ry) && ({1'b0, in_col_q} > rx));
    scan_end  = (y_q == y1_q) && (x_q == x1_q);
    is_last   = ({1'b0, out_row_q} == h_eff - 13'd1) &&
                ({1'b0, out_col_q} == w_eff - 11'd1);
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (in_acc) state_d = ST_CHECK;
      ST_CHECK: state_d = ready_win ? ST_SCAN : ST_IDLE;
      ST_SCAN:  if (scan_end) state_d = ST_DRAIN;
      ST_DRAIN: state_d = ST_EMIT;
      ST_EMIT:  if (out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // line store: write on pixel acceptance until the frame is in, read one sample per scan cycle
  logic store_we;
  assign store_we = in_acc && (s_axis_tuser == OpPixel) && !in_done_q;

  lgrf_ram #(.Depth(StoreDepth), .DataW(8)) u_store (
    .clk_i   (clk_i),
    .we_i    (store_we),
    .waddr_i ({in_row_q[SlotW-1:0], in_col_q}),
    .wdata_i (s_axis_tdata),
    .raddr_i ({y_q[SlotW-1:0], x_q}),
    .rdata_o (rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      img_w_q    <= WidthReset;
      img_h_q    <= HeightReset;
      win_h_q    <= WinReset;
      win_w_q    <= WinReset;
      in_col_q   <= '0;
      in_row_q   <= '0;
      out_col_q  <= '0;
      out_row_q  <= '0;
      in_done_q  <= 1'b0;
      rd_vld_q   <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      rd_vld_q <= (state_q == ST_SCAN);
      // load a new result word, or drop the one just taken
      if (state_q == ST_EMIT && out_free) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
      if (cfg_we) begin
        // any write restarts the frame
        unique case (paddr[3:2])
          RegImageWidth:  img_w_q <= pwdata[10:0];
          RegImageHeight: img_h_q <= pwdata[12:0];
          RegWinHeight:   win_h_q <= pwdata[3:0];
          RegWinWidth:    win_w_q <= pwdata[3:0];
          default: ;
        endcase
        in_col_q  <= '0;
        in_row_q  <= '0;
        out_col_q <= '0;
        out_row_q <= '0;
        in_done_q <= 1'b0;
      end else if (store_we) begin
        // advance input position
        if ({1'b0, in_col_q} + 11'd1 >= w_eff) begin
          in_col_q <= '0;
          if ({1'b0, in_row_q} + 13'd1 >= h_eff) begin
            in_row_q  <= '0;
            in_done_q <= 1'b1;
          end else begin
            in_row_q <= in_row_q + 12'd1;
          end
        end else begin
          in_col_q <= in_col_q + ColW'(1);
        end
      end else if (state_q == ST_EMIT && out_free) begin
        if (is_last) begin
          in_col_q  <= '0;
          in_row_q  <= '0;
          out_col_q <= '0;
          out_row_q <= '0;
          in_done_q <= 1'b0;
        end else if ({1'b0, out_col_q} + 11'd1 >= w_eff) begin
          out_col_q <= '0;
          out_row_q <= out_row_q + 12'd1;
        end else begin
          out_col_q <= out_col_q + ColW'(1);
        end
      end
    end
  end

  // scan address and running max/min
  always_ff @(posedge clk_i) begin
    if (state_q == ST_CHECK) begin
      y_q   <= y0;
      y1_q  <= ry[11:0];
      x_q   <= x0;
      x0_q  <= x0;
      x1_q  <= rx[ColW-1:0];
      max_q <= '0;
      min_q <= PixMax;
    end else begin
      if (state_q == ST_SCAN && !scan_end) begin
        if (x_q == x1_q) begin
          x_q <= x0_q;
          y_q <= y_q + 12'd1;
        end else begin
          x_q <= x_q + ColW'(1);
        end
      end
      if (rd_vld_q) begin
        if (rd_data > max_q) max_q <= rd_data;
        if (rd_data < min_q) min_q <= rd_data;
      end
    end
    if (state_q == ST_EMIT && out_free) begin
      out_data_q <= max_q - min_q;
      out_last_q <= is_last;
    end
  end

  a_range_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT) |-> (max_q >= min_q))
    else $error("window max below window min");

  a_col_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, in_col_q} < w_eff) && ({1'b0, out_col_q} < w_eff))
    else $error("column counter beyond row width");

  a_accept_check: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == ST_CHECK))
    else $error("accepted word not checked");

  a_scan_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DRAIN) |-> rd_vld_q)
    else $error("final window sample missing");

endmodule
